@@ hw/rtl/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the go-back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 7;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int WIN_W      = 4;
    localparam int MAX_WINDOW = 8;
    localparam int WIN_RESET  = 4;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 3;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2,
        CMD_UNKNOWN = 2'd3
    } cmd_t;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;

    typedef struct packed {
        cmd_t             cmd;
        logic [SEQ_W-1:0] fseq;
        logic [SEQ_W-1:0] ack;
        logic [LEN_W-1:0] len;
        logic [WIN_W-1:0] win;
    } entry_t;

    typedef struct packed {
        logic                transmit;
        logic [SLOT_W-1:0]   slot;
        logic [SEQ_W-1:0]    seq;
        logic [LEN_W-1:0]    len;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

@@ hw/rtl/go_back_n_sender_window_top.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top
// Go-back-N ARQ sender window: ring of frame descriptors, send/ack/timeout.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tuser: command; tdata: seq, ack, length
//  m_axis    out  tvalid/tready        tuser: transmit, status; tdata: slot,
//                                      seq, length; tlast: final result
//  cfg       in   cfg_we               cfg_wdata: window size
//
//  Send stores a frame; ack releases frames until a frame stops the walk;
//  timeout walks the outstanding frames (at most 8). The walk is paced by
//  the single registered read port of the slot memory.
//  Reset clears the ring counters; no memory clearing pass is needed.
//  A two-item queue takes input while the engine works or the output stalls.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_top #(
    parameter int RING_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gbn_pkg::WIN_W-1:0]           cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // frame_seq[31:0], ack_number[63:32], frame_length[70:64], pad
    input  logic [gbn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command[1:0]
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // slot[5:0], tx_seq[37:6], tx_length[44:38], pad
    output logic [gbn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // transmit[0], status[2:1]
    output logic [gbn_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast
);

    logic             q_full;
    logic             q_push;
    gbn_pkg::entry_t  q_in;
    logic             q_pop;
    logic             q_valid;
    gbn_pkg::entry_t  q_out;
    gbn_pkg::result_t res;

    gbn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_cmd     (s_axis_tuser),
        .s_fseq    (s_axis_tdata[31:0]),
        .s_ack     (s_axis_tdata[63:32]),
        .s_len     (s_axis_tdata[70:64]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    gbn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_out)
    );

    gbn_engine #(
        .RING_DEPTH (RING_DEPTH)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_entry  (q_out),
        .m_result (res),
        .m_last   (m_axis_tlast),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready)
    );

    assign m_axis_tdata = {3'b000, res.len, res.seq, res.slot};
    assign m_axis_tuser = {res.status, res.transmit};

endmodule

@@ hw/rtl/gbn_front.sv @@
// ----------------------------------------------------------------------------
// gbn_front
// Input side: holds the window register, clamps it and decodes each item.
// ----------------------------------------------------------------------------
module gbn_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gbn_pkg::WIN_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_cmd,
    input  logic [gbn_pkg::SEQ_W-1:0]     s_fseq,
    input  logic [gbn_pkg::SEQ_W-1:0]     s_ack,
    input  logic [gbn_pkg::LEN_W-1:0]     s_len,
    input  logic                          q_full,
    output logic                          q_push,
    output gbn_pkg::entry_t               q_entry
);

    logic [gbn_pkg::WIN_W-1:0] window_reg;
    logic [gbn_pkg::WIN_W-1:0] window_next;
    logic [gbn_pkg::WIN_W-1:0] win_eff;

    always_comb
    begin
        window_next = window_reg;
        if (cfg_we)
        begin
            window_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= gbn_pkg::WIN_W'(gbn_pkg::WIN_RESET);
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    // effective window is 1..8
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = gbn_pkg::WIN_W'(1);
        end
        else if (window_reg > gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW))
        begin
            win_eff = gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW);
        end
        else
        begin
            win_eff = window_reg;
        end
    end

    always_comb
    begin
        q_entry.cmd  = gbn_pkg::cmd_t'(s_cmd);
        q_entry.fseq = s_fseq;
        q_entry.ack  = s_ack;
        q_entry.len  = s_len;
        q_entry.win  = win_eff;
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

@@ hw/rtl/gbn_queue.sv @@
// ----------------------------------------------------------------------------
// gbn_queue
// Two-entry item queue between the front and the engine.
// ----------------------------------------------------------------------------
module gbn_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gbn_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output gbn_pkg::entry_t pop_entry
);

    gbn_pkg::entry_t entries_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_entry = entries_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (do_pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hw/rtl/gbn_engine.sv @@
// ----------------------------------------------------------------------------
// gbn_engine
// Back end: slot memory, ring counters and the send / ack / timeout walker.
// ----------------------------------------------------------------------------
module gbn_engine #(
    parameter int RING_DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  gbn_pkg::entry_t   q_entry,
    output gbn_pkg::result_t  m_result,
    output logic              m_last,
    output logic              m_valid,
    input  logic              m_ready
);

    localparam int IW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(2 * RING_DEPTH);
    localparam int SW = (IW > gbn_pkg::SLOT_W) ? IW : gbn_pkg::SLOT_W;
    localparam int XW = (CW > gbn_pkg::WIN_W) ? CW : gbn_pkg::WIN_W;
    localparam int MW = gbn_pkg::SEQ_W + gbn_pkg::LEN_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
    localparam logic [CW-1:0] TWOD_C  = CW'(2 * RING_DEPTH);
    localparam logic [CW-1:0] WRAP_C  = CW'(2 * RING_DEPTH - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_TRY      = 7'b0000010,
        S_EMIT     = 7'b0000100,
        S_ACK_NEXT = 7'b0001000,
        S_ACK_CHK  = 7'b0010000,
        S_TO_CHK   = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    function automatic logic [CW-1:0] ctr_inc(input logic [CW-1:0] c);
        if (c == WRAP_C)
        begin
            return '0;
        end
        return c + CW'(1);
    endfunction

    function automatic logic [CW-1:0] ctr_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        if (a >= b)
        begin
            return a - b;
        end
        return a - b + TWOD_C;
    endfunction

    function automatic logic [IW-1:0] ctr_slot(input logic [CW-1:0] c);
        logic [CW-1:0] t;
        t = (c >= DEPTH_C) ? (c - DEPTH_C) : c;
        return t[IW-1:0];
    endfunction

    // slot memory: {length, sequence}
    logic [MW-1:0] mem [RING_DEPTH];
    logic [MW-1:0] rd_data_reg;
    logic [IW-1:0] rd_addr_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;
    logic          mem_re;
    logic [IW-1:0] mem_raddr;

    state_t                         state_reg, state_next;
    gbn_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [gbn_pkg::SEQ_W-1:0]      fseq_reg, fseq_next;
    logic [gbn_pkg::SEQ_W-1:0]      ack_reg, ack_next;
    logic [gbn_pkg::WIN_W-1:0]      win_reg, win_next;
    logic [gbn_pkg::WIN_W-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]                  ptr_reg, ptr_next;
    logic [CW-1:0]                  oldest_reg, oldest_next;
    logic [CW-1:0]                  nts_reg, nts_next;
    logic [CW-1:0]                  free_reg, free_next;
    logic [gbn_pkg::STATUS_W-1:0]   status_reg, status_next;
    gbn_pkg::result_t               held_reg, held_next;
    logic                           held_valid_reg, held_valid_next;
    gbn_pkg::result_t               out_reg;
    logic                           out_last_reg;
    logic                           out_valid_reg;

    logic                           out_free;
    logic                           out_load;
    gbn_pkg::result_t               out_data_in;
    logic                           out_last_in;
    logic                           can_produce;
    logic                           produce;
    gbn_pkg::result_t               frame;
    gbn_pkg::result_t               idle_res;
    logic [CW-1:0]                  outstanding;
    logic [gbn_pkg::WIN_W-1:0]      cnt_init;
    logic                           try_ok;
    logic [SW-1:0]                  slot_ext;
    logic [gbn_pkg::SEQ_W-1:0]      rd_seq;
    logic [gbn_pkg::LEN_W-1:0]      rd_len;

    assign rd_seq   = rd_data_reg[gbn_pkg::SEQ_W-1:0];
    assign rd_len   = rd_data_reg[MW-1:gbn_pkg::SEQ_W];
    assign slot_ext = SW'(rd_addr_reg);

    assign out_free    = !out_valid_reg || m_ready;
    assign can_produce = !held_valid_reg || out_free;

    assign outstanding = ctr_diff(nts_reg, oldest_reg);
    assign try_ok      = (free_reg != nts_reg) && (XW'(outstanding) < XW'(win_reg));
    assign cnt_init    = (XW'(outstanding) > XW'(gbn_pkg::MAX_WINDOW)) ?
                         gbn_pkg::WIN_W'(gbn_pkg::MAX_WINDOW) : gbn_pkg::WIN_W'(outstanding);

    always_comb
    begin
        frame.transmit = 1'b1;
        frame.slot     = slot_ext[gbn_pkg::SLOT_W-1:0];
        frame.seq      = rd_seq;
        frame.len      = rd_len;
        frame.status   = gbn_pkg::ST_OK;

        idle_res.transmit = 1'b0;
        idle_res.slot     = '0;
        idle_res.seq      = '0;
        idle_res.len      = '0;
        idle_res.status   = status_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        fseq_next       = fseq_reg;
        ack_next        = ack_reg;
        win_next        = win_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        oldest_next     = oldest_reg;
        nts_next        = nts_reg;
        free_next       = free_reg;
        status_next     = status_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = ctr_slot(free_reg);
        mem_wdata       = {q_entry.len, q_entry.fseq};
        mem_re          = 1'b0;
        mem_raddr       = ctr_slot(oldest_reg);
        produce         = 1'b0;
        out_load        = 1'b0;
        out_data_in     = held_reg;
        out_last_in     = 1'b0;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    cmd_next    = q_entry.cmd;
                    fseq_next   = q_entry.fseq;
                    ack_next    = q_entry.ack;
                    win_next    = q_entry.win;
                    cnt_next    = cnt_init;
                    ptr_next    = oldest_reg;
                    status_next = gbn_pkg::ST_OK;
                    case (q_entry.cmd)
                        gbn_pkg::CMD_SEND:
                        begin
                            if (ctr_diff(free_reg, oldest_reg) >= DEPTH_C)
                            begin
                                status_next = gbn_pkg::ST_FULL;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                free_next  = ctr_inc(free_reg);
                                state_next = S_TRY;
                            end
                        end
                        gbn_pkg::CMD_ACK:
                        begin
                            if (cnt_init == '0)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_ACK_CHK;
                            end
                        end
                        gbn_pkg::CMD_TIMEOUT:
                        begin
                            if (cnt_init == '0)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_TO_CHK;
                            end
                        end
                        default:
                        begin
                            status_next = gbn_pkg::ST_UNKNOWN;
                            state_next  = S_FINISH;
                        end
                    endcase
                end
            end

            S_TRY:
            begin
                if (try_ok)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ctr_slot(nts_reg);
                    nts_next   = ctr_inc(nts_reg);
                    state_next = S_EMIT;
                end
                else if (cmd_reg == gbn_pkg::CMD_ACK)
                begin
                    state_next = S_ACK_NEXT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_EMIT:
            begin
                if (can_produce)
                begin
                    produce = 1'b1;
                    if (cmd_reg == gbn_pkg::CMD_ACK)
                    begin
                        state_next = S_ACK_NEXT;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_ACK_NEXT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_ACK_CHK;
                end
            end

            S_ACK_CHK:
            begin
                if (ack_reg < rd_seq)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    oldest_next = ctr_inc(oldest_reg);
                    cnt_next    = cnt_reg - gbn_pkg::WIN_W'(1);
                    state_next  = S_TRY;
                end
            end

            S_TO_CHK:
            begin
                if ((rd_seq < fseq_reg) || can_produce)
                begin
                    produce  = (rd_seq >= fseq_reg);
                    cnt_next = cnt_reg - gbn_pkg::WIN_W'(1);
                    ptr_next = ctr_inc(ptr_reg);
                    if (cnt_reg == gbn_pkg::WIN_W'(1))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = ctr_slot(ctr_inc(ptr_reg));
                    end
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_last_in     = 1'b1;
                    out_data_in     = held_valid_reg ? held_reg : idle_res;
                    held_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // one result is held back until it is known whether it is the final one
        if (produce)
        begin
            if (held_valid_reg)
            begin
                out_load    = 1'b1;
                out_data_in = held_reg;
                out_last_in = 1'b0;
            end
            held_next       = frame;
            held_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            oldest_reg     <= '0;
            nts_reg        <= '0;
            free_reg       <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            oldest_reg     <= oldest_next;
            nts_reg        <= nts_next;
            free_reg       <= free_next;
            held_valid_reg <= held_valid_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        fseq_reg   <= fseq_next;
        ack_reg    <= ack_next;
        win_reg    <= win_next;
        cnt_reg    <= cnt_next;
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        held_reg   <= held_next;
        if (out_load)
        begin
            out_reg      <= out_data_in;
            out_last_reg <= out_last_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
            rd_addr_reg <= mem_raddr;
        end
    end

    assign m_result = out_reg;
    assign m_last   = out_last_reg;
    assign m_valid  = out_valid_reg;

endmodule
